### rtl/core/bba_pkg.sv
// Shared constants and types for the buddy block allocator.
// No dependencies.
package bba_pkg;

	localparam int unsigned MinExpDefault      = 5;
	localparam int unsigned MaxExpDefault      = 16;
	localparam int unsigned HeaderBytesDefault = 8;

	localparam logic [1:0] StatusDone    = 2'd0;
	localparam logic [1:0] StatusNoFit   = 2'd1;
	localparam logic [1:0] StatusUnknown = 2'd2;

	localparam logic ModeAlloc = 1'b0;
	localparam logic ModeFree  = 1'b1;

	typedef logic [31:0] addr_t;

endpackage

### rtl/core/buddy_block_allocator.sv
// Binary buddy allocator: sequencer over a free-mark memory and a level memory.
// Depends on bba_pkg.
//
//   channel   signals                                   direction
//   request   start, mode, request_bytes, free_address  in (busy blocks)
//   result    done, granted_address, status             out (one-cycle strobe)
//   config    psel, penable, pwrite, paddr, pwdata      in, prdata/pready out
//
// Reset runs a clearing pass over both memories, busy high throughout. An
// allocate reads and checks one tree node at a time (up to 2^(L+1)-1 nodes
// for a full search) plus split steps; a free reads and checks one merge
// level at a time. One shared read port per memory sets the pace.
// The result strobe cannot be stalled.
module buddy_block_allocator #(
	parameter int unsigned MIN_EXP      = bba_pkg::MinExpDefault,
	parameter int unsigned MAX_EXP      = bba_pkg::MaxExpDefault,
	parameter int unsigned HEADER_BYTES = bba_pkg::HeaderBytesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [15:0]         request_bytes,
	input  bba_pkg::addr_t      free_address,
	output logic                done,
	output bba_pkg::addr_t      granted_address,
	output logic [1:0]          status,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import bba_pkg::*;

	localparam int unsigned Levels = MAX_EXP - MIN_EXP;
	localparam int unsigned NodeW  = Levels + 1;          // index of 2^(L+1)-1 nodes
	localparam int unsigned SlotW  = (Levels > 0) ? Levels : 1;
	localparam int unsigned LvlW   = $clog2(Levels + 2);
	localparam int unsigned ExpW   = 5;
	localparam int unsigned OffW   = MAX_EXP + 1;
	localparam int unsigned NodeCount = (2 << Levels) - 1;
	localparam int unsigned SlotCount = 1 << Levels;

	// sequencer codes
	localparam logic [3:0] SIdle   = 4'd0;
	localparam logic [3:0] SClr    = 4'd1;
	localparam logic [3:0] SFit    = 4'd2;
	localparam logic [3:0] SScanRd = 4'd3;
	localparam logic [3:0] SScanCk = 4'd4;
	localparam logic [3:0] SSplit  = 4'd5;
	localparam logic [3:0] SFreeRd = 4'd6;
	localparam logic [3:0] SFreeCk = 4'd7;
	localparam logic [3:0] SMrgRd  = 4'd8;
	localparam logic [3:0] SMrgCk  = 4'd9;
	localparam logic [3:0] SMark   = 4'd10;
	localparam logic [3:0] SDone   = 4'd11;

	logic [3:0]       state_q;
	logic [31:0]      base_q;
	logic [16:0]      need_q;
	logic [ExpW-1:0]  e_q;       // wanted / current exponent
	logic [ExpW-1:0]  j_q;       // scan exponent
	logic [OffW-1:0]  p_q;       // position in level / offset of block
	logic [1:0]       st_q;
	addr_t            grant_q;
	logic             done_q;
	logic [NodeW:0]   clr_q;

	// memories
	logic             fm_mem [NodeCount];
	logic [LvlW-1:0]  al_mem [SlotCount];
	logic             fm_we, fm_wd, fm_rd_q;
	logic [NodeW-1:0] fm_wa, fm_ra;
	logic             al_we;
	logic [LvlW-1:0]  al_wd, al_rd_q;
	logic [SlotW-1:0] al_wa, al_ra;

	always_ff @(posedge clk) begin
		if (fm_we) fm_mem[fm_wa] <= fm_wd;
		fm_rd_q <= fm_mem[fm_ra];
	end
	always_ff @(posedge clk) begin
		if (al_we) al_mem[al_wa] <= al_wd;
		al_rd_q <= al_mem[al_ra];
	end

	// node index of block of size 2^e at offset off
	function automatic logic [NodeW-1:0] node_of(input logic [ExpW-1:0] e,
			input logic [OffW-1:0] off);
		logic [ExpW-1:0]  d;
		logic [NodeW:0]   first;
		logic [OffW-1:0]  pos;
		d = ExpW'(MAX_EXP) - e;
		first = (NodeW+1)'((1 << d) - 1);
		pos = off >> e;
		return NodeW'(first + (NodeW+1)'(pos));
	endfunction

	logic [OffW-1:0] cnt_j;   // blocks at scan level
	logic [OffW-1:0] mate;
	logic [OffW-1:0] blk_off;
	assign cnt_j   = OffW'(1) << (ExpW'(MAX_EXP) - j_q);
	assign blk_off = p_q << j_q;
	assign mate    = p_q ^ (OffW'(1) << e_q);

	// memory port control
	always_comb begin
		fm_we = 1'b0; fm_wd = 1'b0; fm_wa = '0;
		al_we = 1'b0; al_wd = '0; al_wa = '0;
		fm_ra = '0; al_ra = '0;
		case (state_q)
			SClr: begin
				fm_we = (clr_q < (NodeW+1)'(NodeCount));
				fm_wa = clr_q[NodeW-1:0];
				fm_wd = (clr_q == '0);
				al_we = (clr_q < (NodeW+1)'(SlotCount));
				al_wa = clr_q[SlotW-1:0];
			end
			SScanRd: fm_ra = node_of(j_q, p_q << j_q);
			SScanCk: if (fm_rd_q) begin
				fm_we = 1'b1; fm_wa = node_of(j_q, blk_off);
			end
			SSplit: if (e_q != j_q) begin
				fm_we = 1'b1; fm_wd = 1'b1;
				fm_wa = node_of(j_q - 1'b1, blk_off + (OffW'(1) << (j_q - 1'b1)));
			end else begin
				al_we = 1'b1; al_wa = SlotW'(blk_off >> MIN_EXP);
				al_wd = LvlW'(e_q - ExpW'(MIN_EXP) + 1'b1);
			end
			SFreeRd: al_ra = SlotW'(p_q >> MIN_EXP);
			SFreeCk: if (al_rd_q != '0 && al_rd_q <= LvlW'(Levels + 1)) begin
				al_we = 1'b1; al_wa = SlotW'(p_q >> MIN_EXP);
			end
			SMrgRd: fm_ra = node_of(e_q, mate);
			SMrgCk: if (fm_rd_q && e_q < ExpW'(MAX_EXP)) begin
				fm_we = 1'b1; fm_wa = node_of(e_q, mate);
			end
			SMark: begin
				fm_we = 1'b1; fm_wd = 1'b1; fm_wa = node_of(e_q, p_q);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SClr;
			clr_q   <= '0;
			base_q  <= '0;
			done_q  <= 1'b0;
			need_q  <= '0;
			e_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
			st_q    <= StatusDone;
			grant_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (psel && penable && pwrite && paddr == 2'd0) base_q <= pwdata;
			case (state_q)
				SClr: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (NodeW+1)'(NodeCount)) state_q <= SIdle;
				end
				SIdle: if (start) begin
					need_q  <= 17'(request_bytes) + 17'(HEADER_BYTES);
					e_q     <= ExpW'(MIN_EXP);
					st_q    <= StatusDone;
					grant_q <= '0;
					state_q <= (mode == ModeFree) ? SFreeRd : SFit;
					if (mode == ModeFree) begin
						p_q <= OffW'(free_address - 32'(HEADER_BYTES) - base_q);
						if ((free_address - 32'(HEADER_BYTES) - base_q) >= (32'(1) << MAX_EXP)
							|| ((free_address - 32'(HEADER_BYTES) - base_q)
								& ((32'(1) << MIN_EXP) - 1)) != '0) begin
							st_q <= StatusUnknown;
							state_q <= SDone;
						end
					end
				end
				// one exponent step per cycle
				SFit: begin
					if (e_q > ExpW'(MAX_EXP)) begin
						st_q <= StatusNoFit; state_q <= SDone;
					end else if ((32'(1) << e_q) >= 32'(need_q)) begin
						j_q <= e_q; p_q <= '0; state_q <= SScanRd;
					end else e_q <= e_q + 1'b1;
				end
				SScanRd: state_q <= SScanCk;
				SScanCk: begin
					if (fm_rd_q) state_q <= SSplit;
					else if (p_q + 1'b1 < cnt_j) begin
						p_q <= p_q + 1'b1; state_q <= SScanRd;
					end else if (j_q < ExpW'(MAX_EXP)) begin
						j_q <= j_q + 1'b1; p_q <= '0; state_q <= SScanRd;
					end else begin
						st_q <= StatusNoFit; state_q <= SDone;
					end
				end
				// free upper halves from j-1 down to e
				SSplit: begin
					if (e_q != j_q) j_q <= j_q - 1'b1;
					else begin
						grant_q <= base_q + 32'(blk_off) + 32'(HEADER_BYTES);
						state_q <= SDone;
					end
					if (e_q != j_q) p_q <= blk_off >> (j_q - 1'b1);
				end
				SFreeRd: state_q <= SFreeCk;
				SFreeCk: begin
					if (al_rd_q == '0 || al_rd_q > LvlW'(Levels + 1)) begin
						st_q <= StatusUnknown; state_q <= SDone;
					end else begin
						e_q <= ExpW'(MIN_EXP) + ExpW'(al_rd_q) - 1'b1;
						state_q <= SMrgRd;
					end
				end
				SMrgRd: state_q <= (e_q < ExpW'(MAX_EXP)) ? SMrgCk : SMark;
				SMrgCk: begin
					if (fm_rd_q) begin
						if (mate < p_q) p_q <= mate;
						e_q <= e_q + 1'b1;
						state_q <= SMrgRd;
					end else state_q <= SMark;
				end
				SMark: state_q <= SDone;
				SDone: begin
					done_q <= 1'b1; state_q <= SIdle;
				end
				default: state_q <= SIdle;
			endcase
		end
	end

	// p_q in split holds position at level j; blk_off = p<<j stays the block base
	assign busy            = (state_q != SIdle);
	assign done            = done_q;
	assign granted_address = done_q ? grant_q : '0;
	assign status          = st_q;
	assign prdata          = (paddr == 2'd0) ? base_q : '0;
	assign pready          = 1'b1;

endmodule
